// ===== design/socct_pkg.sv =====
// shared types and constants for the shape overlap and containment test
// no dependencies; used by shape_overlap_containment_test and socct_sq
package socct_pkg;

  localparam int CoordW  = 32;
  localparam int WideW   = CoordW + 2;      // room for a sum of three coordinates
  localparam int DiffMagW = CoordW;         // magnitude of a coordinate difference
  localparam int ThrMagW = CoordW + 1;      // magnitude of a radius threshold
  localparam int SumW    = 2 * ThrMagW;     // squared distances and thresholds
  localparam int CfgIdxW = 3;
  localparam int NumAxes = 3;
  localparam int NumThr  = 4;

  localparam logic [1:0] SHAPE_RECT    = 2'd0;
  localparam logic [1:0] SHAPE_BOX     = 2'd1;
  localparam logic [1:0] SHAPE_SPHERE  = 2'd2;
  localparam logic [1:0] SHAPE_INVALID = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_TYPE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_C0   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_C1   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_C2   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_C3   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_C4   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_C5   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_CLR  = 3'd7;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [1:0] query_type;
    coord_t     query_c0;
    coord_t     query_c1;
    coord_t     query_c2;
    coord_t     query_c3;
    coord_t     query_c4;
    coord_t     query_c5;
  } in_word_t;

  typedef struct packed {
    logic overlap;
    logic query_inside;
    logic region_inside;
    logic pair_error;
  } out_word_t;

  // control that travels down the pipe with each word
  typedef struct packed {
    logic       vld;
    logic       rr;
    logic       bb;
    logic       bs;
    logic       ss;
    logic       q_sph;
    logic       rr_ovl;
    logic       bb_ovl;
    logic       in_qg_lin;
    logic       in_gq_lin;
    logic       sib_c;
    logic       sib_0;
    logic [NumAxes-1:0] lt;
    logic [NumAxes-1:0] gt;
    logic       t0_pos;
    logic       t1_nn;
    logic       t2_nn;
    logic       t3_nn;
  } ctl_t;

  function automatic logic signed [WideW-1:0] sx(coord_t v);
    logic signed [WideW-1:0] r;
    r = {{(WideW-CoordW){v[CoordW-1]}}, v};
    return r;
  endfunction

endpackage

// ===== design/shape_overlap_containment_test.sv =====
// throughput: one word per cycle, busy is always low; the six stages are
// input capture, differences, magnitudes, squaring, sums, compares
// results cannot be stalled; out_valid strobes for one cycle per word
// synchronous active-low reset empties the pipe and restores the region
// registers to a zero box with zero clearance
module shape_overlap_containment_test import socct_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_word,
  output logic               out_valid,
  output out_word_t          out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CoordW-1:0]  cfg_data
);

  // configuration
  logic [1:0] rg_type_r;
  coord_t     rg_c_r [6];
  coord_t     clr_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rg_type_r <= SHAPE_BOX;
      for (int i = 0; i < 6; i++) rg_c_r[i] <= '0;
      clr_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TYPE: rg_type_r <= cfg_data[1:0];
        REG_C0:   rg_c_r[0] <= cfg_data;
        REG_C1:   rg_c_r[1] <= cfg_data;
        REG_C2:   rg_c_r[2] <= cfg_data;
        REG_C3:   rg_c_r[3] <= cfg_data;
        REG_C4:   rg_c_r[4] <= cfg_data;
        REG_C5:   rg_c_r[5] <= cfg_data;
        REG_CLR:  clr_r     <= cfg_data;
        default:  clr_r     <= clr_r;
      endcase
    end
  end

  // stage 1: capture
  logic     s1_vld_r;
  in_word_t s1_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_q_r <= in_word;
  end

  // stage 2: role selection, differences, linear tests
  coord_t qc [6];
  coord_t bx [6];
  coord_t pc [NumAxes];
  coord_t lc [NumAxes];
  coord_t hc [NumAxes];
  coord_t sph_rad;
  ctl_t   ctl2;
  logic signed [CoordW:0]  da2 [NumAxes];
  logic signed [CoordW:0]  db2 [NumAxes];
  logic signed [WideW-1:0] t2v [NumThr];
  logic       qs, gs;

  always_comb begin
    qc[0] = s1_q_r.query_c0;
    qc[1] = s1_q_r.query_c1;
    qc[2] = s1_q_r.query_c2;
    qc[3] = s1_q_r.query_c3;
    qc[4] = s1_q_r.query_c4;
    qc[5] = s1_q_r.query_c5;
    qs = s1_q_r.query_type == SHAPE_SPHERE;
    gs = rg_type_r == SHAPE_SPHERE;
    ctl2 = '0;
    ctl2.vld = s1_vld_r;
    ctl2.rr = s1_q_r.query_type == SHAPE_RECT && rg_type_r == SHAPE_RECT;
    ctl2.bb = s1_q_r.query_type == SHAPE_BOX && rg_type_r == SHAPE_BOX;
    ctl2.bs = (s1_q_r.query_type == SHAPE_BOX && gs) ||
              (qs && rg_type_r == SHAPE_BOX);
    ctl2.ss = qs && gs;
    ctl2.q_sph = qs;
    for (int i = 0; i < 6; i++) bx[i] = qs ? rg_c_r[i] : qc[i];
    sph_rad = qs ? qc[3] : rg_c_r[3];
    // sphere-sphere reuses the low slot for center differences
    for (int k = 0; k < NumAxes; k++) begin
      pc[k] = (qs && !ctl2.ss) ? qc[k] : rg_c_r[k];
      lc[k] = ctl2.ss ? qc[k] : bx[2*k];
      hc[k] = ctl2.ss ? qc[k] : bx[2*k+1];
      da2[k] = (CoordW+1)'(sx(pc[k]) - sx(lc[k]));
      db2[k] = (CoordW+1)'(sx(pc[k]) - sx(hc[k]));
      ctl2.lt[k] = $signed(pc[k]) < $signed(lc[k]);
      ctl2.gt[k] = $signed(pc[k]) > $signed(hc[k]);
    end
    ctl2.rr_ovl = 1'b1;
    ctl2.bb_ovl = 1'b1;
    ctl2.in_qg_lin = 1'b1;
    ctl2.in_gq_lin = 1'b1;
    ctl2.sib_c = 1'b1;
    ctl2.sib_0 = 1'b1;
    for (int k = 0; k < NumAxes; k++) begin
      if (!($signed(qc[2*k]) < $signed(rg_c_r[2*k+1]) &&
            $signed(qc[2*k+1]) > $signed(rg_c_r[2*k]))) begin
        ctl2.bb_ovl = 1'b0;
        if (k < 2) ctl2.rr_ovl = 1'b0;
      end
      if (sx(qc[2*k]) < sx(rg_c_r[2*k]) + sx(clr_r) ||
          sx(qc[2*k+1]) > sx(rg_c_r[2*k+1]) - sx(clr_r)) ctl2.in_qg_lin = 1'b0;
      if (sx(rg_c_r[2*k]) < sx(qc[2*k]) + sx(clr_r) ||
          sx(rg_c_r[2*k+1]) > sx(qc[2*k+1]) - sx(clr_r)) ctl2.in_gq_lin = 1'b0;
      if (sx(sph_rad) > sx(pc[k]) - sx(bx[2*k]) - sx(clr_r) ||
          sx(sph_rad) > sx(bx[2*k+1]) - sx(pc[k]) - sx(clr_r)) ctl2.sib_c = 1'b0;
      if (sx(sph_rad) > sx(pc[k]) - sx(bx[2*k]) ||
          sx(sph_rad) > sx(bx[2*k+1]) - sx(pc[k])) ctl2.sib_0 = 1'b0;
    end
    if (ctl2.ss) begin
      t2v[0] = sx(qc[3]) + sx(rg_c_r[3]) + sx(clr_r);
      t2v[1] = sx(qc[3]) - sx(rg_c_r[3]);
      t2v[2] = sx(rg_c_r[3]) - sx(qc[3]) - sx(clr_r);
      t2v[3] = sx(qc[3]) - sx(rg_c_r[3]) - sx(clr_r);
    end else begin
      t2v[0] = sx(sph_rad) + sx(clr_r);
      t2v[1] = sx(sph_rad);
      t2v[2] = sx(sph_rad) - sx(clr_r);
      t2v[3] = '0;
    end
  end

  ctl_t s2_ctl_r;
  logic signed [CoordW:0]  s2_da_r [NumAxes];
  logic signed [CoordW:0]  s2_db_r [NumAxes];
  logic signed [WideW-1:0] s2_t_r  [NumThr];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_ctl_r <= '0;
    else        s2_ctl_r <= ctl2;
  end

  always_ff @(posedge clk) begin
    s2_da_r <= da2;
    s2_db_r <= db2;
    s2_t_r  <= t2v;
  end

  // stage 3: magnitudes and threshold signs
  ctl_t s3_ctl_r;
  ctl_t ctl3;
  logic [DiffMagW-1:0] s3_ma_r [NumAxes];
  logic [DiffMagW-1:0] s3_mb_r [NumAxes];
  logic [ThrMagW-1:0]  s3_mt_r [NumThr];

  always_comb begin
    ctl3 = s2_ctl_r;
    ctl3.t0_pos = s2_t_r[0] > 0;
    ctl3.t1_nn  = !s2_t_r[1][WideW-1];
    ctl3.t2_nn  = !s2_t_r[2][WideW-1];
    ctl3.t3_nn  = !s2_t_r[3][WideW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_ctl_r <= '0;
    else        s3_ctl_r <= ctl3;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumAxes; k++) begin
      s3_ma_r[k] <= DiffMagW'(s2_da_r[k][CoordW] ? -s2_da_r[k] : s2_da_r[k]);
      s3_mb_r[k] <= DiffMagW'(s2_db_r[k][CoordW] ? -s2_db_r[k] : s2_db_r[k]);
    end
    for (int j = 0; j < NumThr; j++) begin
      s3_mt_r[j] <= ThrMagW'(s2_t_r[j][WideW-1] ? -s2_t_r[j] : s2_t_r[j]);
    end
  end

  // stage 4: squaring
  ctl_t s4_ctl_r;
  logic [2*DiffMagW-1:0] pa [NumAxes];
  logic [2*DiffMagW-1:0] pb [NumAxes];
  logic [SumW-1:0]       pt [NumThr];

  always_ff @(posedge clk) begin
    if (!rst_n) s4_ctl_r <= '0;
    else        s4_ctl_r <= s3_ctl_r;
  end

  for (genvar k = 0; k < NumAxes; k++) begin : g_axis
    socct_sq #(.W(DiffMagW)) u_sqa (.clk(clk), .a(s3_ma_r[k]), .sq(pa[k]));
    socct_sq #(.W(DiffMagW)) u_sqb (.clk(clk), .a(s3_mb_r[k]), .sq(pb[k]));
  end

  for (genvar j = 0; j < NumThr; j++) begin : g_thr
    socct_sq #(.W(ThrMagW)) u_sqt (.clk(clk), .a(s3_mt_r[j]), .sq(pt[j]));
  end

  // stage 5: clamped gap, farthest corner and center distance
  ctl_t s5_ctl_r;
  logic [SumW-1:0] s5_gap_r, s5_far_r, s5_d_r;
  logic [SumW-1:0] s5_t_r [NumThr];
  logic [SumW-1:0] gap5, far5, d5;

  always_comb begin
    gap5 = '0;
    far5 = '0;
    d5   = '0;
    for (int k = 0; k < NumAxes; k++) begin
      if (s4_ctl_r.lt[k])      gap5 = gap5 + SumW'(pa[k]);
      else if (s4_ctl_r.gt[k]) gap5 = gap5 + SumW'(pb[k]);
      far5 = far5 + SumW'((pa[k] >= pb[k]) ? pa[k] : pb[k]);
      d5   = d5 + SumW'(pa[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_ctl_r <= '0;
    else        s5_ctl_r <= s4_ctl_r;
  end

  always_ff @(posedge clk) begin
    s5_gap_r <= gap5;
    s5_far_r <= far5;
    s5_d_r   <= d5;
    s5_t_r   <= pt;
  end

  // stage 6: final compares
  out_word_t res6;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      bis0, bisc, bs_ovl;

  always_comb begin
    bis0   = s5_ctl_r.t1_nn && s5_far_r <= s5_t_r[1];
    bisc   = s5_ctl_r.t2_nn && s5_far_r <= s5_t_r[2];
    bs_ovl = s5_gap_r < s5_t_r[0] && !bis0 && !s5_ctl_r.sib_0;
    res6   = '0;
    priority if (s5_ctl_r.rr || s5_ctl_r.bb) begin
      res6.overlap       = s5_ctl_r.rr ? s5_ctl_r.rr_ovl : s5_ctl_r.bb_ovl;
      res6.query_inside  = s5_ctl_r.in_qg_lin;
      res6.region_inside = s5_ctl_r.in_gq_lin;
    end else if (s5_ctl_r.bs) begin
      res6.overlap       = bs_ovl;
      res6.query_inside  = s5_ctl_r.q_sph ? s5_ctl_r.sib_c : bisc;
      res6.region_inside = s5_ctl_r.q_sph ? bisc : s5_ctl_r.sib_c;
    end else if (s5_ctl_r.ss) begin
      res6.overlap       = s5_ctl_r.t0_pos && s5_d_r < s5_t_r[0] && s5_d_r > s5_t_r[1];
      res6.query_inside  = s5_ctl_r.t2_nn && s5_d_r <= s5_t_r[2];
      res6.region_inside = s5_ctl_r.t3_nn && s5_d_r <= s5_t_r[3];
    end else begin
      res6.pair_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= s5_ctl_r.vld;
  end

  always_ff @(posedge clk) begin
    out_word_r <= res6;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##6 out_valid)
    else $error("accepted word did not come out after six cycles");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.pair_error |->
      !out_word.overlap && !out_word.query_inside && !out_word.region_inside)
    else $error("unsupported pair produced a true answer");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s5_ctl_r.vld))
    else $error("result strobe without a word in the pipe");
`endif

endmodule

// ===== design/socct_sq.sv =====
// registered unsigned squarer, one multiply per stage
// depends on socct_pkg
module socct_sq import socct_pkg::*; #(
  parameter int W = ThrMagW
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  output logic [2*W-1:0] sq
);

  logic [2*W-1:0] sq_r;

  always_ff @(posedge clk) begin
    sq_r <= (2*W)'(a) * (2*W)'(a);
  end

  assign sq = sq_r;

endmodule
